// File: rtl/rtusfr_pkg.sv
package rtusfr_pkg;

    // store geometry: two banks of FRAME_DEPTH bytes
    localparam int FRAME_DEPTH = 256;
    localparam int IDX_W       = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W      = $clog2(2 * FRAME_DEPTH);
    localparam int LEN_W       = 9;

    // silence register reset value and saturation limit
    localparam logic [7:0] SILENCE_RESET = 8'd35;
    localparam logic [7:0] SILENCE_MAX   = 8'd255;

    // register index of silence_bits
    localparam logic REG_SILENCE = 1'b0;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2,
        KIND_POLL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RCV  = 2'd1,
        MODE_ERR  = 2'd2
    } mode_t;

    // byte store access request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // per-transaction result fields, read data excluded
    typedef struct packed {
        logic             frame_done;
        logic [LEN_W-1:0] frame_length;
        logic             ready_flag;
        logic             overflow;
        logic             rd_hit;
    } res_t;

endpackage

// File: rtl/rtusfr_store.sv
module rtusfr_store (
    input  logic                  aclk,
    input  rtusfr_pkg::mem_req_t  req,
    input  logic                  rd_en,
    output logic [7:0]            rd_data
);

    logic [7:0] mem [2*rtusfr_pkg::FRAME_DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rtusfr_ctrl.sv
module rtusfr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [1:0]            kind,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            read_index,
    input  logic [7:0]            silence_bits,
    output rtusfr_pkg::mem_req_t  req,
    output rtusfr_pkg::res_t      res
);

    rtusfr_pkg::mode_t              mode_reg, mode_next;
    logic [7:0]                     cnt_reg, cnt_next;
    logic                           armed_reg, armed_next;
    logic                           bank_reg, bank_next;
    logic [rtusfr_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [rtusfr_pkg::CNT_W-1:0]   plen_reg, plen_next;
    logic                           flag_reg, flag_next;

    logic [7:0]                     cnt_inc;
    logic                           silence_end;
    logic                           store_full;
    logic [rtusfr_pkg::IDX_W-1:0]   fill_idx;
    logic [rtusfr_pkg::IDX_W-1:0]   rd_idx;
    rtusfr_pkg::kind_t              kind_t_val;

    assign kind_t_val  = rtusfr_pkg::kind_t'(kind);
    assign cnt_inc     = (cnt_reg < rtusfr_pkg::SILENCE_MAX) ? cnt_reg + 8'd1 : cnt_reg;
    assign silence_end = (cnt_inc >= silence_bits);
    assign store_full  = (fill_reg >= rtusfr_pkg::CNT_W'(rtusfr_pkg::FRAME_DEPTH));
    assign fill_idx    = fill_reg[rtusfr_pkg::IDX_W-1:0];
    assign rd_idx      = read_index[rtusfr_pkg::IDX_W-1:0];

    // store addressing: fill bank for writes, other bank for reads
    always_comb begin
        req.wr_data = rx_byte;
        req.wr_addr = bank_reg
            ? rtusfr_pkg::ADDR_W'(rtusfr_pkg::FRAME_DEPTH) + rtusfr_pkg::ADDR_W'(fill_idx)
            : rtusfr_pkg::ADDR_W'(fill_idx);
        req.rd_addr = bank_reg
            ? rtusfr_pkg::ADDR_W'(rd_idx)
            : rtusfr_pkg::ADDR_W'(rtusfr_pkg::FRAME_DEPTH) + rtusfr_pkg::ADDR_W'(rd_idx);
        req.wr_en   = fire && (kind_t_val == rtusfr_pkg::KIND_BYTE)
                      && (mode_reg != rtusfr_pkg::MODE_ERR) && !store_full;
    end

    // next state
    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        armed_next = armed_reg;
        bank_next  = bank_reg;
        fill_next  = fill_reg;
        plen_next  = plen_reg;
        flag_next  = flag_reg;
        unique case (kind_t_val)
            rtusfr_pkg::KIND_BYTE: begin
                if (mode_reg != rtusfr_pkg::MODE_ERR) begin
                    if (!store_full) begin
                        fill_next = fill_reg + rtusfr_pkg::CNT_W'(1);
                        mode_next = rtusfr_pkg::MODE_RCV;
                    end else begin
                        fill_next = '0;
                        mode_next = rtusfr_pkg::MODE_ERR;
                    end
                end
                armed_next = 1'b1;
                cnt_next   = '0;
            end
            rtusfr_pkg::KIND_TICK: begin
                if (armed_reg) begin
                    if (silence_end) begin
                        if (mode_reg == rtusfr_pkg::MODE_RCV) begin
                            flag_next = 1'b1;
                            plen_next = fill_reg;
                            bank_next = ~bank_reg;
                        end
                        fill_next  = '0;
                        mode_next  = rtusfr_pkg::MODE_IDLE;
                        armed_next = 1'b0;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            rtusfr_pkg::KIND_READ: begin
            end
            rtusfr_pkg::KIND_POLL: begin
                flag_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // result fields
    always_comb begin
        res.frame_done   = (kind_t_val == rtusfr_pkg::KIND_TICK) && armed_reg && silence_end
                           && (mode_reg == rtusfr_pkg::MODE_RCV);
        res.overflow     = (kind_t_val == rtusfr_pkg::KIND_BYTE)
                           && (mode_reg != rtusfr_pkg::MODE_ERR) && store_full;
        res.ready_flag   = (kind_t_val == rtusfr_pkg::KIND_POLL) && flag_reg;
        res.rd_hit       = (kind_t_val == rtusfr_pkg::KIND_READ)
                           && (rtusfr_pkg::LEN_W'(read_index) < rtusfr_pkg::LEN_W'(plen_reg))
                           && (rtusfr_pkg::LEN_W'(read_index)
                               < rtusfr_pkg::LEN_W'(rtusfr_pkg::FRAME_DEPTH));
        res.frame_length = rtusfr_pkg::LEN_W'(plen_next);
    end

    // state registers, updated per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= rtusfr_pkg::MODE_IDLE;
            cnt_reg   <= '0;
            armed_reg <= 1'b0;
            bank_reg  <= 1'b0;
            fill_reg  <= '0;
            plen_reg  <= '0;
            flag_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            armed_reg <= armed_next;
            bank_reg  <= bank_next;
            fill_reg  <= fill_next;
            plen_reg  <= plen_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

// File: rtl/rtu_silence_framed_receiver_core.sv
// pipeline: a result passes through the result stage and then the output register to the m_ channel
// throughput: one transaction per cycle while the m_ channel is not stalled, set by the
//   single-pass state update and the registered read port of the byte store
// reset: synchronous active-low aresetn clears mode, timer, bank, counts, flag and
//   pipeline valids; silence_bits returns to 35; byte store contents are not cleared
module rtu_silence_framed_receiver_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_read_index,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_done,
    output logic [8:0]  m_frame_length,
    output logic [7:0]  m_read_data,
    output logic        m_ready_flag,
    output logic        m_overflow,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                  s_fire;
    logic                  s1_adv;
    logic                  s1_valid_reg;
    rtusfr_pkg::res_t      s1_res_reg;
    rtusfr_pkg::res_t      res;
    rtusfr_pkg::mem_req_t  req;
    logic [7:0]            rd_data;
    logic [7:0]            silence_reg;

    logic                  m_valid_reg;
    logic                  m_frame_done_reg;
    logic [8:0]            m_frame_length_reg;
    logic [7:0]            m_read_data_reg;
    logic                  m_ready_flag_reg;
    logic                  m_overflow_reg;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rtusfr_pkg::REG_SILENCE) ? {24'd0, silence_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            silence_reg <= rtusfr_pkg::SILENCE_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == rtusfr_pkg::REG_SILENCE)) begin
            silence_reg <= pwdata[7:0];
        end
    end

    // pipeline handshake
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;

    rtusfr_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (s_fire),
        .kind         (s_kind),
        .rx_byte      (s_rx_byte),
        .read_index   (s_read_index),
        .silence_bits (silence_reg),
        .req          (req),
        .res          (res)
    );

    rtusfr_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_en   (s_fire),
        .rd_data (rd_data)
    );

    // result stage alongside the store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_res_reg <= res;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_frame_done_reg   <= s1_res_reg.frame_done;
            m_frame_length_reg <= s1_res_reg.frame_length;
            m_read_data_reg    <= s1_res_reg.rd_hit ? rd_data : 8'd0;
            m_ready_flag_reg   <= s1_res_reg.ready_flag;
            m_overflow_reg     <= s1_res_reg.overflow;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_done   = m_frame_done_reg;
    assign m_frame_length = m_frame_length_reg;
    assign m_read_data    = m_read_data_reg;
    assign m_ready_flag   = m_ready_flag_reg;
    assign m_overflow     = m_overflow_reg;

endmodule

// File: rtl/rtusfr_checker.sv
module rtusfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_frame_done,
    input logic [8:0] m_frame_length,
    input logic [7:0] m_read_data,
    input logic       m_ready_flag,
    input logic       m_overflow
);

    // a frame end, an overflow and a ready flag come from different transaction kinds
    a_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_done && m_overflow) && !(m_ready_flag && m_overflow)
                    && !(m_ready_flag && m_frame_done))
        else $error("exclusive result flags set together");

    // packet length never exceeds the bank size
    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_length <= 9'd256))
        else $error("frame length beyond bank size");

    // a nonzero read byte needs a nonempty packet
    a_read_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_data != 8'd0)) |-> (m_frame_length != 9'd0))
        else $error("read data from an empty packet");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_frame_length)
                                   && $stable(m_read_data)))
        else $error("stalled result changed");

endmodule

bind rtu_silence_framed_receiver_core rtusfr_checker u_rtusfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_done   (m_frame_done),
    .m_frame_length (m_frame_length),
    .m_read_data    (m_read_data),
    .m_ready_flag   (m_ready_flag),
    .m_overflow     (m_overflow)
);
